FILE: hw/rtl/ael_pkg.sv
// Package for the arithmetic expression tokenizer: token kinds, scan phases,
// character codes, the queue entry type and the operator decode function.
// No dependencies.
package ael_pkg;

   // Token kinds as they appear on the result channel
   typedef enum logic [3:0] {
      TK_INTEGER = 4'd0,
      TK_REAL    = 4'd1,
      TK_LPAREN  = 4'd2,
      TK_RPAREN  = 4'd3,
      TK_PLUS    = 4'd4,
      TK_MINUS   = 4'd5,
      TK_MUL     = 4'd6,
      TK_DIV     = 4'd7,
      TK_COMMA   = 4'd8,
      TK_END     = 4'd9
   } token_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_INT  = 2'd1,
      PH_FRAC = 2'd2
   } scan_phase_type;

   localparam logic [7:0] CharNul    = 8'h00;
   localparam logic [7:0] CharLparen = 8'h28;
   localparam logic [7:0] CharRparen = 8'h29;
   localparam logic [7:0] CharMul    = 8'h2A;
   localparam logic [7:0] CharPlus   = 8'h2B;
   localparam logic [7:0] CharComma  = 8'h2C;
   localparam logic [7:0] CharMinus  = 8'h2D;
   localparam logic [7:0] CharDot    = 8'h2E;
   localparam logic [7:0] CharDiv    = 8'h2F;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;

   localparam int MaxFracDigits     = 18;
   localparam int QueueDepthDefault = 4;

   localparam int IntW       = 63;
   localparam int FracW      = 60;
   localparam int FracCountW = 5;

   // One queue entry: what a single character leaves for the back end.
   // Up to two tokens: a finished number, then the character's own token.
   typedef struct packed {
      logic                  num_valid;
      logic                  num_real;
      logic [IntW-1:0]       int_value;
      logic [FracW-1:0]      frac_value;
      logic [FracCountW-1:0] frac_digits;
      logic                  overflow;
      logic                  op_valid;
      token_kind_type        op_kind;
   } ael_entry_type;

   function automatic token_kind_type op_kind(input logic [7:0] ch);
      token_kind_type k;
      case (ch)
         CharPlus:   k = TK_PLUS;
         CharMinus:  k = TK_MINUS;
         CharMul:    k = TK_MUL;
         CharDiv:    k = TK_DIV;
         CharLparen: k = TK_LPAREN;
         CharRparen: k = TK_RPAREN;
         CharComma:  k = TK_COMMA;
         default:    k = TK_END;
      endcase
      return k;
   endfunction

endpackage

FILE: hw/rtl/ael_if.sv
// Channel interfaces of the tokenizer: character input and token output.
// Valid/ready handshake; no dependencies.
interface ael_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source(output valid, output char_code, input ready);
   modport sink(input valid, input char_code, output ready);
endinterface

interface ael_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  token_kind;
   logic [62:0] int_value;
   logic [59:0] frac_value;
   logic [4:0]  frac_digits;
   logic        overflow;
   logic        last_of_run;

   modport source(output valid, output token_kind, output int_value, output frac_value,
                  output frac_digits, output overflow, output last_of_run, input ready);
   modport sink(input valid, input token_kind, input int_value, input frac_value,
                input frac_digits, input overflow, input last_of_run, output ready);
endinterface

FILE: hw/rtl/arith_expression_tokenizer.sv
// Channel    Dir  Handshake      Payload
// req_chan   in   valid/ready    char_code[7:0]
// rsp_chan   out  valid/ready    token_kind, int_value, frac_value, frac_digits,
//                                overflow, last_of_run
//
// Takes one character per cycle unless the queue is full; the scanner
// updates its accumulators in the same cycle (one 67-bit add and compare
// for the integer part). Tokens leave one per cycle while rsp ready is high,
// from a registered output stage; a character that ends a number and is an
// operator itself yields two tokens. A queue of QUEUE_DEPTH entries lets
// the front keep taking characters while the output is stalled; req ready
// drops only when that queue is full. Reset is synchronous and active high.
// Depends on ael_pkg, ael_if, ael_front, ael_queue, ael_back.
module arith_expression_tokenizer
   import ael_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input logic       clock,
   input logic       reset,
   ael_req_if.sink   req_chan,
   ael_rsp_if.source rsp_chan
);

   logic          q_push;
   ael_entry_type q_push_entry;
   logic          q_full;
   logic          q_pop;
   logic          q_head_valid;
   ael_entry_type q_head_entry;

   // Front: classify characters, build numbers
   ael_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_char_code (req_chan.char_code),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_push_entry)
   );

   // Decoupling queue, one entry per token-producing character
   ael_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   // Back: split entries into single tokens, mark the last of each run
   ael_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_entry      (q_head_entry),
      .pop             (q_pop),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_token_kind  (rsp_chan.token_kind),
      .rsp_int_value   (rsp_chan.int_value),
      .rsp_frac_value  (rsp_chan.frac_value),
      .rsp_frac_digits (rsp_chan.frac_digits),
      .rsp_overflow    (rsp_chan.overflow),
      .rsp_last_of_run (rsp_chan.last_of_run)
   );

endmodule

FILE: hw/rtl/ael_front.sv
// Front end of the tokenizer: accepts one character per cycle when the queue
// has room, runs the number scanner and queues finished tokens. Uses ael_pkg.
module ael_front
   import ael_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_char_code,
   input  logic          q_full,
   output logic          q_push,
   output ael_entry_type q_entry
);

   scan_phase_type        phase_ff, phase_in;
   logic [IntW-1:0]       int_accum_ff, int_accum_in;
   logic [FracW-1:0]      frac_accum_ff, frac_accum_in;
   logic [FracCountW-1:0] frac_count_ff, frac_count_in;
   logic                  int_sat_ff, int_sat_in;

   logic                  accept;
   logic                  is_digit;
   logic                  is_op;
   logic                  dot_in_int;
   logic                  ends_number;
   logic [3:0]            digit_val;
   logic [IntW+3:0]       int_wide;
   logic                  int_ovf;
   logic [FracW-1:0]      frac_next;

   assign accept      = req_valid && !q_full;
   assign req_ready   = !q_full;
   assign is_digit    = req_char_code inside {[CharZero:CharNine]};
   assign is_op       = req_char_code inside {CharPlus, CharMinus, CharMul, CharDiv,
                                              CharLparen, CharRparen, CharComma, CharNul};
   assign dot_in_int  = (req_char_code == CharDot) && (phase_ff == PH_INT);
   assign ends_number = !is_digit && !dot_in_int;
   // '0'..'9' sit at 0x30..0x39, so the low nibble is the digit value
   assign digit_val   = req_char_code[3:0];

   // acc*10 + d as acc*8 + acc*2 + d; saturate once it leaves 63 bits
   assign int_wide  = {1'b0, int_accum_ff, 3'b000} + {3'b000, int_accum_ff, 1'b0}
                      + {{IntW{1'b0}}, digit_val};
   assign int_ovf   = int_sat_ff || (int_wide[IntW+3:IntW] != 4'd0);
   assign frac_next = {frac_accum_ff[FracW-4:0], 3'b000} + {frac_accum_ff[FracW-2:0], 1'b0}
                      + {{(FracW-4){1'b0}}, digit_val};

   // Next scan phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (is_digit) begin
            if (phase_ff != PH_FRAC) phase_in = PH_INT;
         end else if (dot_in_int) begin
            phase_in = PH_FRAC;
         end else begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Accumulators
   always_comb begin
      int_accum_in  = int_accum_ff;
      frac_accum_in = frac_accum_ff;
      frac_count_in = frac_count_ff;
      int_sat_in    = int_sat_ff;
      if (accept) begin
         if (is_digit) begin
            if (phase_ff == PH_FRAC) begin
               if (frac_count_ff < FracCountW'(MaxFracDigits)) begin
                  frac_accum_in = frac_next;
                  frac_count_in = frac_count_ff + 1'b1;
               end
            end else if (int_ovf) begin
               int_accum_in = {IntW{1'b1}};
               int_sat_in   = 1'b1;
            end else begin
               int_accum_in = int_wide[IntW-1:0];
            end
         end else if (!dot_in_int) begin
            int_accum_in  = '0;
            frac_accum_in = '0;
            frac_count_in = '0;
            int_sat_in    = 1'b0;
         end
      end
   end

   // Queue entry
   always_comb begin
      q_push              = accept && ends_number && ((phase_ff != PH_IDLE) || is_op);
      q_entry.num_valid   = (phase_ff != PH_IDLE);
      q_entry.num_real    = (phase_ff == PH_FRAC);
      q_entry.int_value   = int_accum_ff;
      q_entry.frac_value  = frac_accum_ff;
      q_entry.frac_digits = frac_count_ff;
      q_entry.overflow    = int_sat_ff;
      q_entry.op_valid    = is_op;
      q_entry.op_kind     = op_kind(req_char_code);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         int_accum_ff  <= '0;
         frac_accum_ff <= '0;
         frac_count_ff <= '0;
         int_sat_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         int_accum_ff  <= int_accum_in;
         frac_accum_ff <= frac_accum_in;
         frac_count_ff <= frac_count_in;
         int_sat_ff    <= int_sat_in;
      end
   end

endmodule

FILE: hw/rtl/ael_queue.sv
// Small circular queue of token entries between front and back end.
// Uses ael_pkg for the entry type.
module ael_queue
   import ael_pkg::*;
#(
   parameter int Depth = QueueDepthDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ael_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          head_valid,
   output ael_entry_type head_entry
);

   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   ael_entry_type   entry_ff [Depth];
   logic [AddrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AddrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AddrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/ael_back.sv
// Back end of the tokenizer: drains queue entries one token per cycle into
// the registered result stage while it is free or being taken. Uses ael_pkg.
module ael_back
   import ael_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ael_entry_type         head_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_token_kind,
   output logic [IntW-1:0]       rsp_int_value,
   output logic [FracW-1:0]      rsp_frac_value,
   output logic [FracCountW-1:0] rsp_frac_digits,
   output logic                  rsp_overflow,
   output logic                  rsp_last_of_run
);

   logic                  valid_ff, valid_in;
   logic                  num_done_ff, num_done_in;
   token_kind_type        kind_ff, kind_in;
   logic [IntW-1:0]       int_ff, int_in;
   logic [FracW-1:0]      frac_ff, frac_in;
   logic [FracCountW-1:0] digits_ff, digits_in;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff, last_in;

   logic                  load;
   logic                  send_num;
   logic                  tok_last;

   assign load     = head_valid && (!valid_ff || rsp_ready);
   assign send_num = head_entry.num_valid && !num_done_ff;
   assign tok_last = send_num ? !head_entry.op_valid : 1'b1;
   assign pop      = load && tok_last;

   always_comb begin
      valid_in    = valid_ff && !rsp_ready;
      num_done_in = num_done_ff;
      kind_in     = kind_ff;
      int_in      = int_ff;
      frac_in     = frac_ff;
      digits_in   = digits_ff;
      ovf_in      = ovf_ff;
      last_in     = last_ff;
      if (load) begin
         valid_in    = 1'b1;
         num_done_in = !tok_last;
         last_in     = tok_last;
         if (send_num) begin
            kind_in   = head_entry.num_real ? TK_REAL : TK_INTEGER;
            int_in    = head_entry.int_value;
            frac_in   = head_entry.num_real ? head_entry.frac_value : '0;
            digits_in = head_entry.num_real ? head_entry.frac_digits : '0;
            ovf_in    = head_entry.overflow;
         end else begin
            kind_in   = head_entry.op_kind;
            int_in    = '0;
            frac_in   = '0;
            digits_in = '0;
            ovf_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         num_done_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         num_done_ff <= num_done_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      int_ff    <= int_in;
      frac_ff   <= frac_in;
      digits_ff <= digits_in;
      ovf_ff    <= ovf_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_token_kind  = kind_ff;
   assign rsp_int_value   = int_ff;
   assign rsp_frac_value  = frac_ff;
   assign rsp_frac_digits = digits_ff;
   assign rsp_overflow    = ovf_ff;
   assign rsp_last_of_run = last_ff;

endmodule

FILE: tb/tb_arith_expression_tokenizer.sv
// Self-checking testbench for arith_expression_tokenizer: character items in,
// token items out, each token checked against the scanner model or a directed row's tokens.
// Depends on ael_pkg, ael_if and the tokenizer RTL.
module tb_arith_expression_tokenizer;
   import ael_pkg::*;

   localparam int          RandomItems = 1200;
   localparam int          CycleLimit  = 400000;
   localparam int          HoldCycles  = 150;    // long receiver hold-off
   localparam int          DrainCycles = 30;     // settle time after the last token
   localparam logic [62:0] IntSat      = {63{1'b1}};
   localparam logic [7:0]  CharSpace   = 8'h20;
   localparam logic [7:0]  CharHigh    = 8'hFF;
   localparam logic [7:0]  CharBit7    = 8'h80;

   // One token as it leaves the block
   typedef struct packed {
      token_kind_type        kind;
      logic [IntW-1:0]       int_value;
      logic [FracW-1:0]      frac_value;
      logic [FracCountW-1:0] frac_digits;
      logic                  overflow;
      logic                  last_of_run;
   } token_type;

   // Directed stimulus row; typed rows carry their own expected tokens,
   // the others are checked against the scanner model.
   typedef struct {
      logic [7:0] ch;
      bit         typed;
      int         n_due;
      token_type  due[2];
   } stim_row_type;

   logic clock;
   logic reset;

   ael_req_if req_chan();
   ael_rsp_if rsp_chan();

   arith_expression_tokenizer dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Scanner model state: mirrors what the block keeps between characters
   scan_phase_type        scan_ph;
   logic [IntW-1:0]       int_acc;
   logic [FracW-1:0]      frac_acc;
   logic [FracCountW-1:0] frac_cnt;
   logic                  int_sat;

   token_type tokens_due[$];  // tokens predicted but not yet seen, oldest first
   int     errors;
   int     cycles;
   int     counted_items;     // accepted characters that did something
   int     burst_left;
   bit     hold_req;          // asks the receiver for one long hold-off

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Cycle counter and run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("** arith_expression_tokenizer: FAILED **");
         $finish;
      end
   end

   function automatic token_type tok(token_kind_type kind, logic [IntW-1:0] iv,
                                     logic [FracW-1:0] fv, logic [FracCountW-1:0] fd,
                                     logic ov, logic last);
      token_type t;
      t.kind        = kind;
      t.int_value   = iv;
      t.frac_value  = fv;
      t.frac_digits = fd;
      t.overflow    = ov;
      t.last_of_run = last;
      return t;
   endfunction

   function automatic stim_row_type row(logic [7:0] ch, bit typed, int n, token_type a,
                                        token_type b);
      stim_row_type r;
      r.ch     = ch;
      r.typed  = typed;
      r.n_due  = n;
      r.due[0] = a;
      r.due[1] = b;
      return r;
   endfunction

   function automatic void clear_scan();
      scan_ph  = PH_IDLE;
      int_acc  = '0;
      frac_acc = '0;
      frac_cnt = '0;
      int_sat  = 1'b0;
   endfunction

   // Scanner model: feeds one character, returns the tokens it causes
   function automatic void scan_char(input logic [7:0] ch, ref token_type toks[$]);
      logic [63:0]    d;
      bit             has_op;
      token_kind_type op;
      toks.delete();
      if (ch >= CharZero && ch <= CharNine) begin
         d = 64'(ch - CharZero);
         if (scan_ph == PH_FRAC) begin
            // digits past the limit are eaten silently
            if (frac_cnt < MaxFracDigits) begin
               frac_acc = frac_acc * 60'd10 + 60'(d);
               frac_cnt = frac_cnt + 1'b1;
            end
         end else begin
            scan_ph = PH_INT;
            // saturate at 2^63-1 and stay there for the rest of the number
            if (int_sat || {1'b0, int_acc} > (64'h7FFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
               int_acc = IntSat;
               int_sat = 1'b1;
            end else begin
               int_acc = int_acc * 63'd10 + 63'(d);
            end
         end
         return;
      end
      // dot right after integer digits opens the fraction
      if (ch == CharDot && scan_ph == PH_INT) begin
         scan_ph = PH_FRAC;
         return;
      end
      has_op = 1'b1;
      case (ch)
         CharPlus:   op = TK_PLUS;
         CharMinus:  op = TK_MINUS;
         CharMul:    op = TK_MUL;
         CharDiv:    op = TK_DIV;
         CharLparen: op = TK_LPAREN;
         CharRparen: op = TK_RPAREN;
         CharComma:  op = TK_COMMA;
         CharNul:    op = TK_END;
         default: begin
            op     = TK_END;
            has_op = 1'b0;
         end
      endcase
      if (scan_ph == PH_INT) begin
         toks.push_back(tok(TK_INTEGER, int_acc, '0, '0, int_sat, !has_op));
      end else if (scan_ph == PH_FRAC) begin
         toks.push_back(tok(TK_REAL, int_acc, frac_acc, frac_cnt, int_sat, !has_op));
      end
      clear_scan();
      if (has_op) begin
         toks.push_back(tok(op, '0, '0, '0, 1'b0, 1'b1));
      end
   endfunction

   function automatic void append_digits(ref logic [7:0] q[$], input int count,
                                         input bit all_nines);
      for (int i = 0; i < count; i++) begin
         q.push_back(all_nines ? CharNine : CharZero + 8'($urandom_range(0, 9)));
      end
   endfunction

   function automatic void append_text(ref logic [7:0] q[$], input string s);
      for (int i = 0; i < s.len(); i++) begin
         q.push_back(s[i]);
      end
   endfunction

   // One number of random shape: mostly short, sometimes at the limits
   function automatic void append_number(ref logic [7:0] q[$]);
      case ($urandom_range(0, 16))
         0, 1, 2, 3, 4, 5, 6: append_digits(q, $urandom_range(1, 3), 1'b0);
         7: begin
            // long run, usually saturates; sometimes a fraction follows
            append_digits(q, $urandom_range(19, 24), $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1) begin
               q.push_back(CharDot);
               append_digits(q, $urandom_range(0, 4), 1'b0);
            end
         end
         8: append_text(q, "9223372036854775807");
         9: append_text(q, "9223372036854775808");
         10, 11, 12: begin
            append_digits(q, $urandom_range(1, 4), 1'b0);
            q.push_back(CharDot);
            append_digits(q, $urandom_range(0, 5), 1'b0);
         end
         13: begin
            append_digits(q, $urandom_range(1, 2), 1'b0);
            q.push_back(CharDot);
            append_digits(q, $urandom_range(16, 22), $urandom_range(0, 2) == 0);
         end
         14: begin
            // second dot ends the real and is dropped
            append_digits(q, $urandom_range(1, 3), 1'b0);
            q.push_back(CharDot);
            append_digits(q, $urandom_range(0, 3), 1'b0);
            q.push_back(CharDot);
         end
         15: begin
            q.push_back(CharZero);
            q.push_back(CharZero);
            append_digits(q, $urandom_range(1, 2), 1'b0);
         end
         default: begin
            append_text(q, "0.");
            append_digits(q, $urandom_range(18, 21), 1'b1);
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("mismatch @%0d: %s got %0h want %0h", cycles, what, got, want);
   endtask

   // Offer one character, wait for it to be taken, then predict its tokens.
   // Sender pacing: bursts of random length with short gaps between.
   task automatic send_char(input stim_row_type r);
      token_type      produced[$];
      scan_phase_type prior;
      int             gap;
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= r.ch;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      prior = scan_ph;
      scan_char(r.ch, produced);
      if (r.typed) begin
         for (int i = 0; i < r.n_due; i++) tokens_due.push_back(r.due[i]);
      end else begin
         foreach (produced[i]) tokens_due.push_back(produced[i]);
      end
      // skipped characters in idle do not count toward the item budget
      if (!(produced.size() == 0 && prior == PH_IDLE && scan_ph == PH_IDLE)) begin
         counted_items++;
      end
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   // Token checker: every accepted token against the oldest prediction
   always @(posedge clock) begin : token_check
      token_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (tokens_due.size() == 0) begin
            report_mismatch("token with none due, kind", 64'(rsp_chan.token_kind), '0);
         end else begin
            want = tokens_due.pop_front();
            if (rsp_chan.token_kind !== want.kind)
               report_mismatch("token_kind", 64'(rsp_chan.token_kind), 64'(want.kind));
            if (rsp_chan.int_value !== want.int_value)
               report_mismatch("int_value", 64'(rsp_chan.int_value), 64'(want.int_value));
            if (rsp_chan.frac_value !== want.frac_value)
               report_mismatch("frac_value", 64'(rsp_chan.frac_value), 64'(want.frac_value));
            if (rsp_chan.frac_digits !== want.frac_digits)
               report_mismatch("frac_digits", 64'(rsp_chan.frac_digits),
                               64'(want.frac_digits));
            if (rsp_chan.overflow !== want.overflow)
               report_mismatch("overflow", 64'(rsp_chan.overflow), 64'(want.overflow));
            if (rsp_chan.last_of_run !== want.last_of_run)
               report_mismatch("last_of_run", 64'(rsp_chan.last_of_run),
                               64'(want.last_of_run));
         end
      end
   end

   // Receiver: spans of always-ready, light and heavy random stalls and a
   // fixed stall pattern; a hold request drops ready for a long stretch so
   // the internal queue fills and the block pushes back on its input.
   initial begin : receiver_pace
      int               mode;
      int               span;
      logic [15:0]      stall_mask;
      stall_mask = 16'b1011_0010_1110_0101;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         for (int k = 0; k < span; k++) begin
            if (hold_req) begin
               rsp_chan.ready <= 1'b0;
               repeat (HoldCycles) @(posedge clock);
               hold_req = 1'b0;
            end
            case (mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_chan.ready <= ($urandom_range(0, 1) == 1);
               default: rsp_chan.ready <= stall_mask[k % 16];
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      stim_row_type dir_table [26];
      logic [7:0]   text[$];
      logic [7:0]   op_chars [5];
      int           terms;
      int           depth;
      int           next_hold;
      int           next_drain;
      token_type    none;

      none       = '0;
      op_chars   = '{CharPlus, CharMinus, CharMul, CharDiv, CharComma};
      errors     = 0;
      cycles     = 0;
      counted_items = 0;
      hold_req   = 1'b0;
      burst_left = $urandom_range(1, 40);
      next_hold  = 300;
      next_drain = 550;
      clear_scan();

      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.char_code <= CharNul;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: operators and end right after reset, skipped bytes
      // (dot with no digits, space, top of range), a real ended by an
      // operator, a bare trailing dot, a second dot in a fraction, and a
      // number flushed by an unknown byte and by the end byte.
      dir_table = '{
         row(CharPlus,         1, 1, tok(TK_PLUS, '0, '0, '0, 0, 1), none),
         row(CharNul,          1, 1, tok(TK_END, '0, '0, '0, 0, 1), none),
         row(CharDot,          1, 0, none, none),
         row(CharSpace,        1, 0, none, none),
         row(CharHigh,         1, 0, none, none),
         row(CharLparen,       1, 1, tok(TK_LPAREN, '0, '0, '0, 0, 1), none),
         row(CharZero + 8'd1,  1, 0, none, none),
         row(CharZero + 8'd2,  1, 0, none, none),
         row(CharDot,          1, 0, none, none),
         row(CharZero + 8'd5,  1, 0, none, none),
         row(CharRparen,       1, 2, tok(TK_REAL, 63'd12, 60'd5, 5'd1, 0, 0),
                                     tok(TK_RPAREN, '0, '0, '0, 0, 1)),
         row(CharZero + 8'd7,  0, 0, none, none),
         row(CharComma,        0, 0, none, none),
         row(CharZero + 8'd3,  0, 0, none, none),
         row(CharDot,          0, 0, none, none),
         row(CharMul,          1, 2, tok(TK_REAL, 63'd3, '0, '0, 0, 0),
                                     tok(TK_MUL, '0, '0, '0, 0, 1)),
         row(CharZero + 8'd4,  0, 0, none, none),
         row(CharDot,          0, 0, none, none),
         row(CharZero + 8'd2,  0, 0, none, none),
         row(CharDot,          1, 1, tok(TK_REAL, 63'd4, 60'd2, 5'd1, 0, 1), none),
         row(CharMinus,        1, 1, tok(TK_MINUS, '0, '0, '0, 0, 1), none),
         row(CharDiv,          1, 1, tok(TK_DIV, '0, '0, '0, 0, 1), none),
         row(CharZero,         1, 0, none, none),
         row(CharBit7,         1, 1, tok(TK_INTEGER, '0, '0, '0, 0, 1), none),
         row(CharNine,         1, 0, none, none),
         row(CharNul,          1, 2, tok(TK_INTEGER, 63'd9, '0, '0, 0, 0),
                                     tok(TK_END, '0, '0, '0, 0, 1))
      };
      foreach (dir_table[i]) send_char(dir_table[i]);
      counted_items = 0;

      // Random part: mostly well-formed expressions with random numbers,
      // operators, parens, spaces and stray bytes; some pure junk strings.
      while (counted_items < RandomItems) begin
         if (counted_items >= next_hold) begin
            // long receiver hold while the sender keeps pushing
            hold_req   = 1'b1;
            burst_left = 90;
            next_hold += 500;
         end
         if (counted_items >= next_drain) begin
            // sender pauses until every predicted token has come out
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (tokens_due.size() != 0);
            next_drain += 500;
         end
         text.delete();
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(0, 255)));
         end else begin
            terms = $urandom_range(1, 6);
            depth = 0;
            for (int t = 0; t < terms; t++) begin
               if (t > 0) text.push_back(op_chars[$urandom_range(0, 4)]);
               if ($urandom_range(0, 4) == 0) begin
                  text.push_back(CharLparen);
                  depth++;
               end
               if ($urandom_range(0, 5) == 0) text.push_back(CharSpace);
               append_number(text);
               if (depth > 0 && $urandom_range(0, 2) == 0) begin
                  text.push_back(CharRparen);
                  depth--;
               end
               if ($urandom_range(0, 11) == 0) text.push_back(8'($urandom_range(0, 255)));
            end
            while (depth > 0) begin
               text.push_back(CharRparen);
               depth--;
            end
            // mostly terminated; otherwise the next string runs on
            if ($urandom_range(0, 7) != 0) text.push_back(CharNul);
         end
         foreach (text[i]) send_char(row(text[i], 1'b0, 0, none, none));
      end

      // Drain: wait for every predicted token, then a quiet stretch
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tokens_due.size() != 0);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("** arith_expression_tokenizer: PASSED **");
      end else begin
         $display("** arith_expression_tokenizer: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/ael_pkg.sv
hw/rtl/ael_if.sv
hw/rtl/ael_front.sv
hw/rtl/ael_queue.sv
hw/rtl/ael_back.sv
hw/rtl/arith_expression_tokenizer.sv
tb/tb_arith_expression_tokenizer.sv
